// ===== rtl/core/als_pkg.sv =====
// Shared types and constants of the addressable LED serializer.
package als_pkg;

  // Width of the unsaturated pulse durations derived from clock_mhz.
  localparam int DUR_W = 16;

  // Configuration register indexes (byte address is 4 * index).
  localparam logic [1:0] REG_CLOCK_MHZ   = 2'd0;
  localparam logic [1:0] REG_COLOR_COUNT = 2'd1;
  localparam logic [1:0] REG_COLOR_ORDER = 2'd2;

  // Colour slot codes.
  localparam logic [1:0] SLOT_NONE  = 2'd0;
  localparam logic [1:0] SLOT_RED   = 2'd1;
  localparam logic [1:0] SLOT_GREEN = 2'd2;
  localparam logic [1:0] SLOT_BLUE  = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef struct packed {
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       end_of_frame;
  } in_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic rejected;
    logic hold_full;
  } out_t;

  // Holding register layout: eof in bit 24, blue 23:16, green 15:8, red 7:0.
  typedef struct packed {
    logic       eof;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    op_t    op;
    pixel_t pixel;
  } cmd_t;

  typedef struct packed {
    logic [9:0] clock_mhz;
    logic [2:0] color_count;
    logic [7:0] color_order;
  } cfg_t;

  typedef struct packed {
    logic [DUR_W-1:0] one_hi;
    logic [DUR_W-1:0] one_lo;
    logic [DUR_W-1:0] zero_hi;
    logic [DUR_W-1:0] zero_lo;
    logic [DUR_W-1:0] latch;
  } dur_t;

endpackage

// ===== rtl/core/als_queue.sv =====
// Small flip-flop FIFO used between the serializer stages.
module als_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Advance pointers with wrap and track the fill level.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming request.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/als_cfg.sv =====
// APB configuration registers and derived pulse durations.
module als_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output als_pkg::cfg_t cfg,
  output als_pkg::dur_t dur
);

  localparam logic [9:0] RESET_CLOCK_MHZ   = 10'd100;
  localparam logic [2:0] RESET_COLOR_COUNT = 3'd3;
  localparam logic [7:0] RESET_COLOR_ORDER = 8'd54;

  logic [9:0]    clock_mhz_r, clock_mhz_nxt;
  logic [2:0]    color_count_r, color_count_nxt;
  logic [7:0]    color_order_r, color_order_nxt;
  als_pkg::dur_t dur_r, dur_nxt;
  logic          wr_en;
  logic [1:0]    reg_idx;

  // Floor of y/5 by reciprocal multiply, exact over 16-bit inputs.
  function automatic logic [15:0] div5(input logic [15:0] y);
    logic [31:0] p;
    p = {16'd0, y} * 32'd52429;
    return {2'b00, p[31:18]};
  endfunction

  // Durations: 800/1000 = 4/5, 400/1000 = 2/5, 450/1000 = 9/20, 850/1000 = 17/20.
  function automatic als_pkg::dur_t calc_durations(input logic [9:0] m);
    logic [15:0]   m16;
    logic [15:0]   m9;
    logic [15:0]   m17;
    als_pkg::dur_t d;
    m16       = {6'd0, m};
    m9        = m16 * 16'd9;
    m17       = m16 * 16'd17;
    d.one_hi  = div5(m16 << 2);
    d.zero_hi = div5(m16 << 1);
    d.one_lo  = div5(m9 >> 2);
    d.zero_lo = div5(m17 >> 2);
    d.latch   = m16 * 16'd60;
    return d;
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = '{clock_mhz: clock_mhz_r, color_count: color_count_r,
                     color_order: color_order_r};
  assign dur     = dur_r;

  // Decode a write request.
  always_comb begin
    clock_mhz_nxt   = clock_mhz_r;
    color_count_nxt = color_count_r;
    color_order_nxt = color_order_r;
    dur_nxt         = dur_r;
    if (wr_en) begin
      unique case (reg_idx)
        als_pkg::REG_CLOCK_MHZ: begin
          clock_mhz_nxt = pwdata[9:0];
          dur_nxt       = calc_durations(pwdata[9:0]);
        end
        als_pkg::REG_COLOR_COUNT: color_count_nxt = pwdata[2:0];
        als_pkg::REG_COLOR_ORDER: color_order_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register.
  always_comb begin
    unique case (reg_idx)
      als_pkg::REG_CLOCK_MHZ:   prdata = {22'd0, clock_mhz_r};
      als_pkg::REG_COLOR_COUNT: prdata = {29'd0, color_count_r};
      als_pkg::REG_COLOR_ORDER: prdata = {24'd0, color_order_r};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_mhz_r   <= RESET_CLOCK_MHZ;
      color_count_r <= RESET_COLOR_COUNT;
      color_order_r <= RESET_COLOR_ORDER;
      dur_r         <= calc_durations(RESET_CLOCK_MHZ);
    end else begin
      clock_mhz_r   <= clock_mhz_nxt;
      color_count_r <= color_count_nxt;
      color_order_r <= color_order_nxt;
      dur_r         <= dur_nxt;
    end
  end

endmodule

// ===== rtl/core/als_front.sv =====
// Input side: classifies incoming requests and queues them as commands.
module als_front #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  als_pkg::in_t  in_data,
  output logic          cmd_valid,
  output als_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  localparam int CMD_W = $bits(als_pkg::cmd_t);

  als_pkg::cmd_t    cls_cmd;
  logic [CMD_W-1:0] q_data;
  logic             q_empty;

  // Classify the request: time tick or pixel offer with packed colours.
  always_comb begin
    cls_cmd.op          = als_pkg::op_t'(in_data.func);
    cls_cmd.pixel.eof   = in_data.end_of_frame;
    cls_cmd.pixel.blue  = in_data.blue;
    cls_cmd.pixel.green = in_data.green;
    cls_cmd.pixel.red   = in_data.red;
  end

  als_queue #(
    .W     (CMD_W),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls_cmd),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd       = als_pkg::cmd_t'(q_data);

endmodule

// ===== rtl/core/als_back.sv =====
// Line engine: holding register, bit phases and latch gap timing.
module als_back #(
  parameter int MAX_COLORS  = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  als_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          res_push,
  output als_pkg::out_t res,
  input  logic          res_full,
  input  als_pkg::cfg_t cfg,
  input  als_pkg::dur_t dur
);

  localparam int SHIFT_W = 8 * MAX_COLORS;
  localparam int BL_W    = $clog2(SHIFT_W + 1);
  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  // Line state.
  als_pkg::phase_t  phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [BL_W-1:0]  bits_r, bits_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic             eof_r, eof_nxt;
  als_pkg::pixel_t  held_r, held_nxt;
  logic             held_valid_r, held_valid_nxt;

  // Saturated durations.
  logic [COUNT_WIDTH-1:0] one_hi_s, one_lo_s, zero_hi_s, zero_lo_s, latch_s;

  // Pixel load.
  logic [2:0]         ld_slots, ld_n;
  logic [1:0]         ld_code;
  logic [7:0]         ld_byte;
  logic [SHIFT_W-1:0] ld_shift;
  logic [BL_W-1:0]    ld_bits;

  // One settle step from the current state.
  als_pkg::phase_t        st_phase;
  logic [COUNT_WIDTH-1:0] st_tick;
  logic [BL_W-1:0]        st_bits;
  logic [SHIFT_W-1:0]     st_shift;
  logic                   st_eof, st_hv;

  // State seen by a tick after at most one step.
  als_pkg::phase_t        ef_phase;
  logic [COUNT_WIDTH-1:0] ef_tick;
  logic [BL_W-1:0]        ef_bits;
  logic [SHIFT_W-1:0]     ef_shift;
  logic                   ef_eof, ef_hv;

  logic cur_settled, st_settled, ef_settled;
  logic act, done;

  function automatic logic [COUNT_WIDTH-1:0] sat_cnt(input logic [als_pkg::DUR_W-1:0] v);
    return ({17'd0, v} > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0] : COUNT_WIDTH'(v);
  endfunction

  function automatic logic is_settled(input als_pkg::phase_t ph,
                                      input logic [COUNT_WIDTH-1:0] tc,
                                      input logic hv);
    return (ph == als_pkg::PH_IDLE) ? !hv : (tc != '0);
  endfunction

  // Clamp durations to the counter width.
  always_comb begin
    one_hi_s  = sat_cnt(dur.one_hi);
    one_lo_s  = sat_cnt(dur.one_lo);
    zero_hi_s = sat_cnt(dur.zero_hi);
    zero_lo_s = sat_cnt(dur.zero_lo);
    latch_s   = sat_cnt(dur.latch);
  end

  // Pack the held pixel's colour bytes in slot order, MSB aligned.
  always_comb begin : load_pack
    ld_slots = (cfg.color_count > 3'(MAX_COLORS)) ? 3'(MAX_COLORS) : cfg.color_count;
    ld_n     = '0;
    ld_shift = '0;
    ld_code  = '0;
    ld_byte  = '0;
    for (int s = 0; s < MAX_COLORS; s++) begin
      ld_code = cfg.color_order[2*s +: 2];
      unique case (ld_code)
        als_pkg::SLOT_NONE:  ld_byte = 8'd0;
        als_pkg::SLOT_RED:   ld_byte = held_r.red;
        als_pkg::SLOT_GREEN: ld_byte = held_r.green;
        als_pkg::SLOT_BLUE:  ld_byte = held_r.blue;
      endcase
      if ((3'(s) < ld_slots) && (ld_code != als_pkg::SLOT_NONE)) begin
        ld_shift[SHIFT_W-8-8*int'(ld_n) +: 8] = ld_byte;
        ld_n = ld_n + 3'd1;
      end
    end
    ld_bits = BL_W'({ld_n, 3'b000});
  end

  // Next state: one phase transition of an expired or idle line.
  always_comb begin : step
    st_phase = phase_r;
    st_tick  = tick_r;
    st_bits  = bits_r;
    st_shift = shift_r;
    st_eof   = eof_r;
    st_hv    = held_valid_r;
    unique case (phase_r)
      als_pkg::PH_IDLE: begin
        st_shift = ld_shift;
        st_bits  = ld_bits;
        st_eof   = held_r.eof;
        st_hv    = 1'b0;
        if (ld_n != 3'd0) begin
          st_phase = als_pkg::PH_HIGH;
          st_tick  = ld_shift[SHIFT_W-1] ? one_hi_s : zero_hi_s;
        end else if (held_r.eof) begin
          st_phase = als_pkg::PH_LATCH;
          st_tick  = latch_s;
        end else begin
          st_phase = als_pkg::PH_IDLE;
          st_tick  = '0;
        end
      end
      als_pkg::PH_HIGH: begin
        st_phase = als_pkg::PH_LOW;
        st_tick  = shift_r[SHIFT_W-1] ? one_lo_s : zero_lo_s;
      end
      als_pkg::PH_LOW: begin
        st_shift = shift_r << 1;
        st_bits  = bits_r - BL_W'(1);
        if (st_bits != '0) begin
          st_phase = als_pkg::PH_HIGH;
          st_tick  = st_shift[SHIFT_W-1] ? one_hi_s : zero_hi_s;
        end else if (eof_r) begin
          st_phase = als_pkg::PH_LATCH;
          st_tick  = latch_s;
        end else begin
          st_phase = als_pkg::PH_IDLE;
          st_tick  = '0;
        end
      end
      als_pkg::PH_LATCH: begin
        st_phase = als_pkg::PH_IDLE;
        st_tick  = '0;
      end
    endcase
  end

  // Pick the current state if it needs no transition, else the stepped one.
  always_comb begin
    cur_settled = is_settled(phase_r, tick_r, held_valid_r);
    st_settled  = is_settled(st_phase, st_tick, st_hv);
    ef_settled  = cur_settled || st_settled;
    ef_phase    = cur_settled ? phase_r      : st_phase;
    ef_tick     = cur_settled ? tick_r       : st_tick;
    ef_bits     = cur_settled ? bits_r       : st_bits;
    ef_shift    = cur_settled ? shift_r      : st_shift;
    ef_eof      = cur_settled ? eof_r        : st_eof;
    ef_hv       = cur_settled ? held_valid_r : st_hv;
  end

  assign act  = cmd_valid && !res_full;
  assign done = act && ((cmd.op == als_pkg::OP_PIXEL) || ef_settled);

  // Commit: store an offered pixel, or advance the line on a tick.
  always_comb begin
    phase_nxt      = phase_r;
    tick_nxt       = tick_r;
    bits_nxt       = bits_r;
    shift_nxt      = shift_r;
    eof_nxt        = eof_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    if (act) begin
      unique case (cmd.op)
        als_pkg::OP_PIXEL: begin
          if (!held_valid_r) begin
            held_nxt       = cmd.pixel;
            held_valid_nxt = 1'b1;
          end
        end
        als_pkg::OP_TICK: begin
          phase_nxt      = ef_phase;
          tick_nxt       = ef_tick;
          bits_nxt       = ef_bits;
          shift_nxt      = ef_shift;
          eof_nxt        = ef_eof;
          held_valid_nxt = ef_hv;
          if (ef_settled && (ef_phase != als_pkg::PH_IDLE)) begin
            tick_nxt = ef_tick - COUNT_WIDTH'(1);
          end
        end
      endcase
    end
  end

  // Outputs: result fields and handshakes.
  always_comb begin
    cmd_pop  = done;
    res_push = done;
    if (cmd.op == als_pkg::OP_PIXEL) begin
      res.pin_level = (phase_r == als_pkg::PH_HIGH);
      res.busy_res  = (phase_r != als_pkg::PH_IDLE);
      res.rejected  = held_valid_r;
      res.hold_full = 1'b1;
    end else begin
      res.pin_level = (ef_phase == als_pkg::PH_HIGH);
      res.busy_res  = (ef_phase != als_pkg::PH_IDLE);
      res.rejected  = 1'b0;
      res.hold_full = ef_hv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= als_pkg::PH_IDLE;
      tick_r       <= '0;
      bits_r       <= '0;
      shift_r      <= '0;
      eof_r        <= 1'b0;
      held_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      tick_r       <= tick_nxt;
      bits_r       <= bits_nxt;
      shift_r      <= shift_nxt;
      eof_r        <= eof_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  // Hold the pixel payload; no reset needed.
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  a_pixel_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    act && (cmd.op == als_pkg::OP_PIXEL) |-> res_push)
    else $error("pixel offer did not complete in one cycle");

  a_reject_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.rejected |-> held_valid_r)
    else $error("pixel rejected while holding register empty");

  a_busy_persists: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && (cmd.op == als_pkg::OP_TICK) && res.busy_res |=> phase_r != als_pkg::PH_IDLE)
    else $error("line went idle right after a busy tick");

endmodule

// ===== rtl/core/addressable_led_serializer_unit.sv =====
// Top level of the addressable LED serializer: config, front, line engine, result queue.
//
//  channel  | ports                                   | moves
//  ---------+-----------------------------------------+-------------------------------
//  input    | push, full, in_data                     | tick or pixel offer request
//  result   | empty, pop, out_data                    | pin level and status per request
//  config   | psel, penable, pwrite, paddr, pwdata,   | clock_mhz, color_count,
//           | prdata, pready                          | color_order at 0x0, 0x4, 0x8
//
// One request per cycle unless a multi-step tick or a full result queue stalls the engine;
// results are registered in the result queue. A tick that crosses zero-length phases is
// retried, one phase transition per step of the line engine, until the line settles.
// Reset restores register defaults, empties both queues and idles the line low.
// full rises when two commands wait; the engine pauses while the result queue is full.
module addressable_led_serializer_unit #(
  parameter int MAX_COLORS  = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  als_pkg::in_t  in_data,
  output logic          empty,
  input  logic          pop,
  output als_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;
  localparam int RES_W     = $bits(als_pkg::out_t);

  als_pkg::cfg_t    cfg;
  als_pkg::dur_t    dur;
  als_pkg::cmd_t    cmd;
  als_pkg::out_t    res;
  logic             cmd_valid, cmd_pop;
  logic             res_push, res_full;
  logic [RES_W-1:0] res_q_data;

  als_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .dur     (dur)
  );

  als_front #(
    .DEPTH (CMD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  als_back #(
    .MAX_COLORS  (MAX_COLORS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full),
    .cfg       (cfg),
    .dur       (dur)
  );

  // Buffer results so the engine keeps going while the consumer stalls.
  als_queue #(
    .W     (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_q_data),
    .empty     (empty)
  );

  assign out_data = als_pkg::out_t'(res_q_data);

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the addressable LED serializer unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index that decodes to nothing; writes to it must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum int {
    SINK_STEADY,
    SINK_MOSTLY,
    SINK_HALF,
    SINK_PERIODIC
  } sink_mode_t;

  // Line predictor and store of expected per-request results.
  class led_line_scoreboard;
    localparam longint unsigned COUNT_MAX = 64'h0000_FFFF;
    localparam int unsigned SLOTS_MAX = 4;

    logic [9:0]       clock_mhz;
    logic [2:0]       color_count;
    logic [7:0]       color_order;
    als_pkg::phase_t  line_ph;
    int unsigned      ticks;
    logic [5:0]       bits_left;
    logic [31:0]      shift_bits;
    logic             cur_eof;
    als_pkg::pixel_t  held;
    logic             held_valid;
    als_pkg::out_t    expected_q[$];
    int               n_checked;
    int               n_mismatch;
    int               n_loaded;
    int               n_refused;
    int               n_latches;

    function new();
      clock_mhz   = 10'd100;
      color_count = 3'd3;
      color_order = 8'd54;
      line_ph     = als_pkg::PH_IDLE;
      ticks       = 0;
      bits_left   = '0;
      shift_bits  = '0;
      cur_eof     = 1'b0;
      held        = '0;
      held_valid  = 1'b0;
      n_checked   = 0;
      n_mismatch  = 0;
      n_loaded    = 0;
      n_refused   = 0;
      n_latches   = 0;
    endfunction

    function void log_mismatch(string msg);
      n_mismatch++;
      if (n_mismatch <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        als_pkg::REG_CLOCK_MHZ:   clock_mhz   = value[9:0];
        als_pkg::REG_COLOR_COUNT: color_count = value[2:0];
        als_pkg::REG_COLOR_ORDER: color_order = value[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        als_pkg::REG_CLOCK_MHZ:   return {22'd0, clock_mhz};
        als_pkg::REG_COLOR_COUNT: return {29'd0, color_count};
        als_pkg::REG_COLOR_ORDER: return {24'd0, color_order};
        default:                  return '0;
      endcase
    endfunction

    function int unsigned clip(longint unsigned v);
      longint unsigned c;
      c = (v > COUNT_MAX) ? COUNT_MAX : v;
      return c[31:0];
    endfunction

    // Duration of the high or low part of the bit at the top of the shifter.
    function int unsigned pulse_ticks(bit high_part);
      longint unsigned m;
      longint unsigned k;
      m = clock_mhz;
      if (shift_bits[31]) k = high_part ? 800 : 450;
      else k = high_part ? 400 : 850;
      return clip(m * k / 1000);
    endfunction

    // Enter the latch gap after a frame's last pixel, else go idle.
    function void finish_pixel();
      longint unsigned m;
      m = clock_mhz;
      if (cur_eof) begin
        line_ph = als_pkg::PH_LATCH;
        ticks = clip(m * 60);
        n_latches++;
      end else begin
        line_ph = als_pkg::PH_IDLE;
        ticks = 0;
      end
    endfunction

    // Pack the held pixel's colour bytes in slot order, first byte at the top.
    function void load_held();
      int unsigned slots;
      int unsigned n;
      logic [1:0]  code;
      logic [7:0]  byte_v;
      slots = (color_count > SLOTS_MAX) ? SLOTS_MAX : color_count;
      n = 0;
      shift_bits = '0;
      for (int s = 0; s < slots; s++) begin
        code = color_order[2*s +: 2];
        if (code != als_pkg::SLOT_NONE) begin
          case (code)
            als_pkg::SLOT_RED:   byte_v = held.red;
            als_pkg::SLOT_GREEN: byte_v = held.green;
            default:             byte_v = held.blue;
          endcase
          shift_bits[31 - 8*n -: 8] = byte_v;
          n++;
        end
      end
      bits_left = 6'(8 * n);
      cur_eof = held.eof;
      held_valid = 1'b0;
      n_loaded++;
      if (bits_left != 0) begin
        line_ph = als_pkg::PH_HIGH;
        ticks = pulse_ticks(1'b1);
      end else begin
        finish_pixel();
      end
    endfunction

    // Walk through every phase that has no ticks left.
    function void settle();
      while (1) begin
        if (line_ph == als_pkg::PH_IDLE) begin
          if (!held_valid) return;
          load_held();
        end else if (ticks != 0) begin
          return;
        end else if (line_ph == als_pkg::PH_HIGH) begin
          line_ph = als_pkg::PH_LOW;
          ticks = pulse_ticks(1'b0);
        end else if (line_ph == als_pkg::PH_LOW) begin
          shift_bits = shift_bits << 1;
          bits_left = bits_left - 6'd1;
          if (bits_left != 0) begin
            line_ph = als_pkg::PH_HIGH;
            ticks = pulse_ticks(1'b1);
          end else begin
            finish_pixel();
          end
        end else begin
          line_ph = als_pkg::PH_IDLE;
          ticks = 0;
        end
      end
    endfunction

    // Advance the predicted line by one accepted request.
    function void note_request(als_pkg::in_t req);
      als_pkg::out_t res;
      res.rejected = 1'b0;
      if (req.func == als_pkg::OP_PIXEL) begin
        if (held_valid) begin
          res.rejected = 1'b1;
          n_refused++;
        end else begin
          held.red   = req.red;
          held.green = req.green;
          held.blue  = req.blue;
          held.eof   = req.end_of_frame;
          held_valid = 1'b1;
        end
      end else begin
        settle();
      end
      res.pin_level = (line_ph == als_pkg::PH_HIGH);
      res.busy_res  = (line_ph != als_pkg::PH_IDLE);
      if (req.func == als_pkg::OP_TICK && line_ph != als_pkg::PH_IDLE && ticks != 0) ticks--;
      res.hold_full = held_valid;
      expected_q.push_back(res);
    endfunction

    function void check_result(als_pkg::out_t got);
      als_pkg::out_t want;
      if (expected_q.size() == 0) begin
        log_mismatch($sformatf("result with nothing expected: pin=%b busy=%b rej=%b hold=%b",
                               got.pin_level, got.busy_res, got.rejected, got.hold_full));
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (got.pin_level !== want.pin_level || got.busy_res !== want.busy_res ||
          got.rejected !== want.rejected || got.hold_full !== want.hold_full)
        log_mismatch($sformatf({"result %0d: expected pin=%b busy=%b rej=%b hold=%b,",
                                " got pin=%b busy=%b rej=%b hold=%b"}, n_checked,
                               want.pin_level, want.busy_res, want.rejected, want.hold_full,
                               got.pin_level, got.busy_res, got.rejected, got.hold_full));
    endfunction
  endclass

  logic          clk;
  logic          rst_n   = 1'b0;
  logic          push    = 1'b0;
  logic          pop     = 1'b0;
  logic          psel    = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite  = 1'b0;
  logic [3:0]    paddr   = '0;
  logic [31:0]   pwdata  = '0;
  als_pkg::in_t  in_data = '0;
  logic          full;
  logic          empty;
  logic          pready;
  logic [31:0]   prdata;
  als_pkg::out_t out_data;

  led_line_scoreboard sb = new();
  int burst_left   = 0;
  int n_full_waits = 0;
  int n_settings   = 0;

  addressable_led_serializer_unit #(
    .MAX_COLORS (4),
    .COUNT_WIDTH(16)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Check every popped result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_result(out_data);
  end

  // Result side: change stall pattern now and then, hold off once for a long stretch.
  initial begin : result_sink
    sink_mode_t mode;
    int         mode_left;
    int         hold_left;
    int         cyc;
    bit         hold_done;
    mode = SINK_STEADY;
    mode_left = 0;
    hold_left = 0;
    cyc = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!hold_done && push && sb.n_checked >= 600) begin
        hold_done = 1'b1;
        hold_left = 200;
      end
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          SINK_STEADY: pop <= 1'b1;
          SINK_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
          SINK_HALF:   pop <= ($urandom_range(0, 1) == 0);
          default:     pop <= ((cyc % 7) < 4);
        endcase
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic als_pkg::in_t random_item(int unsigned pixel_pct);
    als_pkg::in_t it;
    it.func = ($urandom_range(0, 99) < pixel_pct) ? als_pkg::OP_PIXEL : als_pkg::OP_TICK;
    it.red = pick_byte();
    it.green = pick_byte();
    it.blue = pick_byte();
    it.end_of_frame = ($urandom_range(0, 2) == 0);
    return it;
  endfunction

  function automatic als_pkg::in_t pixel_req(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                             logic eof);
    als_pkg::in_t it;
    it.func = als_pkg::OP_PIXEL;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.end_of_frame = eof;
    return it;
  endfunction

  function automatic als_pkg::in_t tick_req();
    als_pkg::in_t it;
    it = '0;
    it.func = als_pkg::OP_TICK;
    return it;
  endfunction

  // Offer one request in bursts with random gaps; hold it until accepted.
  task automatic send_item(input als_pkg::in_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (full) begin
      n_full_waits++;
      @(posedge clk);
    end
    sb.note_request(req);
  endtask

  // Drop push and wait until every expected result has been popped.
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, then read it back where it exists.
  task automatic write_and_verify(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    cfg_access(1'b1, idx, value, rd);
    sb.write_reg(idx, value);
    if (idx != REG_UNUSED) begin
      cfg_access(1'b0, idx, $urandom, rd);
      if (rd !== sb.reg_value(idx))
        sb.log_mismatch($sformatf("register %0d read back %h, expected %h",
                                  idx, rd, sb.reg_value(idx)));
    end
  endtask

  // Program all registers (random upper bits), run random requests, drain results.
  task automatic run_phase(input logic [9:0] mhz, input logic [2:0] cnt, input logic [7:0] ord,
                           input int items, input int unsigned pixel_pct);
    logic [31:0] w;
    w = $urandom;
    w[9:0] = mhz;
    write_and_verify(als_pkg::REG_CLOCK_MHZ, w);
    w = $urandom;
    w[2:0] = cnt;
    write_and_verify(als_pkg::REG_COLOR_COUNT, w);
    w = $urandom;
    w[7:0] = ord;
    write_and_verify(als_pkg::REG_COLOR_ORDER, w);
    n_settings++;
    repeat (items) send_item(random_item(pixel_pct));
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, back-to-back pixels, offers while the holder is full.
    send_item(tick_req());
    send_item(pixel_req(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_item(pixel_req(8'h00, 8'h00, 8'h00, 1'b1));
    repeat (2) send_item(tick_req());
    send_item(pixel_req(8'h00, 8'h00, 8'h00, 1'b1));
    send_item(pixel_req(8'hA5, 8'h5A, 8'h81, 1'b0));
    repeat (12) send_item(tick_req());
    wait_drained();

    // A write to an undecoded address must leave every register alone.
    write_and_verify(REG_UNUSED, $urandom);

    // Zero-length pulses, empty slot sets, saturated slot count, slowest and fastest clocks.
    run_phase(10'd1, 3'd3, 8'd54, 200, 25);
    run_phase(10'd2, 3'd4, 8'hE4, 200, 20);
    run_phase(10'd0, 3'd7, 8'($urandom), 200, 25);
    run_phase(10'd3, 3'd0, 8'd54, 120, 20);
    run_phase(10'd5, 3'd4, 8'h00, 150, 20);
    run_phase(10'd1023, 3'd1, 8'hFF, 40, 20);
    run_phase(10'd1000, 3'd4, 8'h1B, 40, 20);
    run_phase(10'd40, 3'd3, 8'd54, 300, 3);
    for (int p = 0; p < 7; p++)
      run_phase(10'($urandom_range(0, 12)), 3'($urandom_range(0, 7)), 8'($urandom), 150,
                $urandom_range(5, 40));

    $display("Summary: %0d requests checked across %0d register settings, %0d pixels shifted",
             sb.n_checked, n_settings, sb.n_loaded);
    $display("Summary: %0d offers refused, %0d latch gaps, %0d cycles of input held by full",
             sb.n_refused, sb.n_latches, n_full_waits);
    if (sb.n_mismatch == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
